FILE: design/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and constants shared by the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;
  localparam int NUM_PAGES = 16384;
  localparam int MAP_WORDS = NUM_PAGES / 32;
  localparam int AW = $clog2(MAP_WORDS);
  localparam int PW = $clog2(NUM_PAGES);
  localparam logic [14:0] KRP_RESET = 15'd2048;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_INIT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_RUN = 2'd1,
    ST_TAKEN  = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] page_number;
    logic [14:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] first_page;
    logic        was_free;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD1W, S_SCAN_RD, S_SCAN_W, S_SCAN_BIT,
    S_MARK_RD, S_MARK_W, S_MARK_WR, S_DONE
  } state_t;

  // Memory request from the controller to the map RAM.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;
  } mem_req_t;
endpackage

FILE: design/bpa_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_map_ram
// Single-port used-page bitmap with registered read data.
// ----------------------------------------------------------------------------
module bpa_map_ram
  import bpa_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rdata
);
  logic [31:0] mem [MAP_WORDS];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule

FILE: design/bitmap_page_allocator_unit.sv
`timescale 1ns / 1ps
// Free/reserve read the map word, then update it and answer; allocate reads map
//   words in turn, examining bits one by one in partly used words, then marks
//   the run with a read and a write per word, all through the single map RAM port.
// Init and reset sweep all 512 map words, one per cycle; no item is taken
//   during that sweep. One item is in work at a time; the next item is taken
//   the cycle after the result transaction is accepted.
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// First-fit bitmap page allocator with free, reserve and init operations.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [14:0] cfg_data
);
  state_t state_r, state_nxt;
  logic [14:0] krp_r;
  in_item_t item_r, item_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic [31:0] word_r, word_nxt;
  logic [14:0] count_r, count_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic out_valid_r, out_valid_nxt;
  logic boot_r, boot_nxt;
  out_item_t out_r, out_nxt;
  mem_req_t req;
  logic [31:0] rdata;
  logic [15:0] krp_sat;
  logic [PW-1:0] cur_page;
  logic [PW:0] wbase;
  logic [31:0] init_word;

  bpa_map_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign krp_sat = (krp_r > 15'(NUM_PAGES)) ? 16'(NUM_PAGES) : {1'b0, krp_r};
  assign cur_page = {waddr_r, bit_r};
  assign wbase = {1'b0, waddr_r, 5'd0};

  // Build the init pattern for the word being swept
  always_comb begin
    init_word = '0;
    for (int i = 0; i < 32; i++) begin
      init_word[i] = (17'(wbase) + 17'(i)) < 17'(krp_sat);
    end
  end

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krp_r <= KRP_RESET;
    end else if (cfg_we) begin
      krp_r <= cfg_data;
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      waddr_r <= '0;
      out_valid_r <= 1'b0;
      boot_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      waddr_r <= waddr_nxt;
      out_valid_r <= out_valid_nxt;
      boot_r <= boot_nxt;
    end
    item_r <= item_nxt;
    bit_r <= bit_nxt;
    word_r <= word_nxt;
    count_r <= count_nxt;
    start_r <= start_nxt;
    remain_r <= remain_nxt;
    out_r <= out_nxt;
  end

  // Sequence requests through read, modify and write of map words
  always_comb begin
    logic [4:0] lo;
    logic [5:0] span;
    logic [31:0] mask;
    state_nxt = state_r;
    item_nxt = item_r;
    waddr_nxt = waddr_r;
    bit_nxt = bit_r;
    word_nxt = word_r;
    count_nxt = count_r;
    start_nxt = start_r;
    remain_nxt = remain_r;
    out_valid_nxt = out_valid_r && out_stall;
    boot_nxt = boot_r;
    out_nxt = out_r;
    req = '{we: 1'b0, addr: waddr_r, wdata: init_word};
    lo = '0;
    span = '0;
    mask = '0;
    unique case (state_r)
      S_CLEAR: begin
        req.we = 1'b1;
        waddr_nxt = waddr_r + 1'b1;
        if (waddr_r == AW'(MAP_WORDS - 1)) begin
          // The reset sweep answers nothing; an init request does
          boot_nxt = 1'b0;
          state_nxt = boot_r ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          item_nxt = in_data;
          out_nxt = '{status: ST_OK, first_page: '0, was_free: 1'b0};
          waddr_nxt = in_data.page_number[PW-1:5];
          bit_nxt = in_data.page_number[4:0];
          count_nxt = '0;
          unique case (op_t'(in_data.func))
            OP_INIT: begin
              waddr_nxt = '0;
              state_nxt = S_CLEAR;
            end
            OP_ALLOC: begin
              waddr_nxt = '0;
              bit_nxt = '0;
              if (in_data.run_length == '0 ||
                  in_data.run_length > 15'(NUM_PAGES)) begin
                out_nxt.status = ST_BAD;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            default: state_nxt = S_RD1;
          endcase
        end
      end
      S_RD1: state_nxt = S_RD1W;
      S_RD1W: begin
        mask = 32'd1 << bit_r;
        if (op_t'(item_r.func) == OP_FREE) begin
          req.we = 1'b1;
          req.wdata = rdata & ~mask;
        end else if ((rdata & mask) != '0) begin
          out_nxt.status = ST_TAKEN;
        end else begin
          req.we = 1'b1;
          req.wdata = rdata | mask;
          out_nxt.was_free = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SCAN_RD: state_nxt = S_SCAN_W;
      S_SCAN_W: begin
        word_nxt = rdata;
        bit_nxt = '0;
        if (rdata == '0 && 16'(count_r) + 16'd32 < 16'(item_r.run_length)) begin
          // Whole word free and run still short
          if (count_r == '0) start_nxt = cur_page;
          count_nxt = count_r + 15'd32;
          if (waddr_r == AW'(MAP_WORDS - 1)) begin
            out_nxt.status = ST_NO_RUN;
            state_nxt = S_DONE;
          end else begin
            waddr_nxt = waddr_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end else if (rdata == '1) begin
          count_nxt = '0;
          if (waddr_r == AW'(MAP_WORDS - 1)) begin
            out_nxt.status = ST_NO_RUN;
            state_nxt = S_DONE;
          end else begin
            waddr_nxt = waddr_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          state_nxt = S_SCAN_BIT;
        end
      end
      S_SCAN_BIT: begin
        if (word_r[bit_r]) begin
          count_nxt = '0;
        end else begin
          if (count_r == '0) start_nxt = cur_page;
          count_nxt = count_r + 1'b1;
        end
        if (!word_r[bit_r] && count_r + 1'b1 >= item_r.run_length) begin
          // Run found: mark from its start
          out_nxt.first_page = (count_r == '0) ? cur_page : start_r;
          waddr_nxt = (count_r == '0) ? waddr_r : start_r[PW-1:5];
          bit_nxt = (count_r == '0) ? bit_r : start_r[4:0];
          remain_nxt = {1'b0, item_r.run_length};
          state_nxt = S_MARK_RD;
        end else if (bit_r == 5'd31) begin
          bit_nxt = '0;
          if (waddr_r == AW'(MAP_WORDS - 1)) begin
            out_nxt.status = ST_NO_RUN;
            state_nxt = S_DONE;
          end else begin
            waddr_nxt = waddr_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      S_MARK_RD: state_nxt = S_MARK_W;
      S_MARK_W: begin
        lo = bit_r;
        span = (remain_r > 16'(6'd32 - {1'b0, lo})) ? (6'd32 - {1'b0, lo})
                                                       : remain_r[5:0];
        mask = ((span == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << span) - 32'd1)) << lo;
        req.we = 1'b1;
        req.wdata = rdata | mask;
        remain_nxt = remain_r - 16'(span);
        bit_nxt = '0;
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        if (remain_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          waddr_nxt = waddr_r + 1'b1;
          state_nxt = S_MARK_RD;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // Reset sweep must not produce a transaction before an item arrives
  logic seen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) seen_r <= 1'b0;
    else if (in_valid && !in_stall) seen_r <= 1'b1;
  end
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_r) else $error("result without request");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_ok_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> out_data.first_page == '0)
    else $error("page on failure");
`endif
endmodule

FILE: test/bitmap_page_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit_tb
// Drives allocate, free, reserve and init requests into the page allocator
// under bursty input and a stalling receiver. A used-page map kept in the
// scoreboard predicts each reply, and every reply is compared field by field
// in arrival order. The kernel reserved count is rewritten between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit_tb;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;

  // Used-page map, reserved count and the replies still owed by the block
  class alloc_scoreboard;
    bit          used_pages[NUM_PAGES];
    logic [14:0] reserved_count;
    out_item_t   replies_due[$];
    int          errors;

    function void set_reserved(logic [14:0] v);
      reserved_count = v;
    endfunction

    // Clear the map, then mark the low kernel pages, saturating at the top
    function void init_map();
      int n;
      n = (reserved_count > NUM_PAGES) ? NUM_PAGES : int'(reserved_count);
      for (int p = 0; p < NUM_PAGES; p++) used_pages[p] = (p < n);
    endfunction

    function void power_up();
      errors = 0;
      replies_due.delete();
      reserved_count = KRP_RESET;
      init_map();
    endfunction

    // Predict the reply of one accepted request and update the map
    function void note_request(in_item_t req);
      out_item_t rep;
      int        len;
      int        run;
      int        p;
      bit        found;
      rep = '0;
      rep.status = ST_OK;
      len = int'(req.run_length);
      case (op_t'(req.func))
        OP_ALLOC: begin
          if (len == 0 || len > NUM_PAGES) begin
            rep.status = ST_BAD;
          end else begin
            run = 0;
            found = 0;
            for (p = 0; p < NUM_PAGES; p++) begin
              if (used_pages[p]) begin
                run = 0;
              end else begin
                run++;
                if (run >= len) begin
                  found = 1;
                  break;
                end
              end
            end
            if (found) begin
              for (int q = p + 1 - len; q <= p; q++) used_pages[q] = 1;
              rep.first_page = 14'(p + 1 - len);
            end else begin
              rep.status = ST_NO_RUN;
            end
          end
        end
        OP_FREE: begin
          if (int'(req.page_number) >= NUM_PAGES) rep.status = ST_BAD;
          else used_pages[req.page_number] = 0;
        end
        OP_RESERVE: begin
          if (int'(req.page_number) >= NUM_PAGES) begin
            rep.status = ST_BAD;
          end else if (used_pages[req.page_number]) begin
            rep.status = ST_TAKEN;
          end else begin
            used_pages[req.page_number] = 1;
            rep.was_free = 1'b1;
          end
        end
        default: init_map();
      endcase
      replies_due.push_back(rep);
    endfunction

    // Compare one reply against the oldest prediction
    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("reply with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.first_page !== want.first_page) begin
        $error("first_page: expected %0d, got %0d", want.first_page, got.first_page);
        errors++;
      end
      if (got.was_free !== want.was_free) begin
        $error("was_free: expected %0d, got %0d", want.was_free, got.was_free);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [14:0] cfg_data;

  alloc_scoreboard sb = new();
  bit              long_hold_req;
  int unsigned     cycles;

  bitmap_page_allocator_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check every accepted reply transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_data);
  end

  // Stall the reply channel in stretches of differing character
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 150);
        repeat (span) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 80);
            default: out_stall <= ((cycles % 4) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Offer one request transaction and hold it until accepted; called at an edge
  task automatic send_item(input in_item_t it, input int gap_after);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
    if (gap_after > 0) begin
      in_valid <= 1'b0;
      repeat (gap_after) @(posedge clk);
    end
  endtask

  function automatic in_item_t make_item(op_t f, int page, int len);
    in_item_t it;
    it.func        = f;
    it.page_number = 14'(page);
    it.run_length  = 15'(len);
    return it;
  endfunction

  // Random request, mostly realistic allocate/free/reserve traffic
  function automatic in_item_t random_item();
    int pick;
    int len;
    int page;
    op_t f;
    pick = $urandom_range(0, 99);
    if (pick < 35)      f = OP_ALLOC;
    else if (pick < 65) f = OP_FREE;
    else if (pick < 96) f = OP_RESERVE;
    else                f = OP_INIT;
    pick = $urandom_range(0, 99);
    if (pick < 70)      len = $urandom_range(1, 16);
    else if (pick < 90) len = $urandom_range(1, 600);
    else if (pick < 96) len = $urandom_range(0, 32767);
    else                len = $urandom_range(NUM_PAGES - 1, NUM_PAGES + 1);
    if ($urandom_range(0, 9) < 6) page = $urandom_range(0, 4095);
    else                          page = $urandom() & 14'h3fff;
    return make_item(f, page, len);
  endfunction

  // Let every reply drain, then pause with no traffic
  task automatic drain();
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reserved(input logic [14:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reserved(v);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic gap_send(input in_item_t it);
    send_item(it, $urandom_range(0, 3));
  endtask

  initial begin
    logic [14:0] settings[6];
    int          burst;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    cycles   = 0;
    long_hold_req = 0;
    sb.power_up();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: map after reset, bad lengths, reserve and free corners
    gap_send(make_item(OP_ALLOC, 0, 0));
    gap_send(make_item(OP_ALLOC, 16383, NUM_PAGES + 1));
    gap_send(make_item(OP_ALLOC, 0, 32767));
    gap_send(make_item(OP_ALLOC, 0, 1));
    gap_send(make_item(OP_ALLOC, 0, 32));
    gap_send(make_item(OP_ALLOC, 0, 100));
    gap_send(make_item(OP_RESERVE, 0, 0));
    gap_send(make_item(OP_RESERVE, 16383, 32767));
    gap_send(make_item(OP_RESERVE, 16383, 0));
    gap_send(make_item(OP_FREE, 0, 0));
    gap_send(make_item(OP_FREE, 0, 0));
    gap_send(make_item(OP_ALLOC, 0, 1));
    gap_send(make_item(OP_FREE, 16383, 0));
    send_item(make_item(OP_INIT, 9999, 77), 1);
    drain();

    // Directed: empty map, whole-map run, run ending on the top page
    write_reserved(15'd0);
    gap_send(make_item(OP_INIT, 0, 0));
    gap_send(make_item(OP_ALLOC, 0, NUM_PAGES));
    gap_send(make_item(OP_ALLOC, 0, 1));
    gap_send(make_item(OP_FREE, 16383, 0));
    gap_send(make_item(OP_FREE, 16382, 0));
    gap_send(make_item(OP_ALLOC, 0, 2));
    gap_send(make_item(OP_RESERVE, 8191, 0));
    send_item(make_item(OP_INIT, 0, 0), 1);
    drain();

    settings[0] = KRP_RESET;
    settings[1] = 15'd0;
    settings[2] = 15'(NUM_PAGES);
    settings[3] = 15'h7fff;
    settings[4] = 15'($urandom_range(0, 100));
    settings[5] = 15'($urandom_range(0, 32767));

    // Random phases, one per reserved-count setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reserved(settings[ph]);
      send_item(make_item(OP_INIT, 0, 0), 1);
      if (ph == 1) long_hold_req = 1;
      burst = 0;
      for (int i = 0; i < 90; i++) begin
        if (burst == 0) burst = $urandom_range(1, 8);
        burst--;
        if (i == 89) send_item(random_item(), 1);
        else if (burst == 0) send_item(random_item(), $urandom_range(1, 6));
        else send_item(random_item(), 0);
      end
      drain();
    end

    while (long_hold_req) @(posedge clk);
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
